FILE: hw/rtl/ckrb_pkg.sv
// shared widths, codes and beat structures of the colour-keyed rectangle blitter
package ckrb_pkg;

	localparam int unsigned DIM_W       = 13;
	localparam int unsigned PITCH_W     = 14;
	localparam int unsigned PIX_W       = 16;
	localparam int unsigned ADDR_W      = 26;
	localparam int unsigned IDX_W       = 3;
	localparam int unsigned CMP_W       = 17;
	localparam int unsigned MAX_DIM     = 4096;
	localparam int unsigned MAX_PITCH   = 16384;

	typedef enum logic [IDX_W-1:0] {
		REG_DST_WIDTH  = 3'd0,
		REG_DST_HEIGHT = 3'd1,
		REG_DST_PITCH  = 3'd2,
		REG_SRC_WIDTH  = 3'd3,
		REG_SRC_HEIGHT = 3'd4,
		REG_SRC_PITCH  = 3'd5
	} cfg_reg_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_PIXEL = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [DIM_W-1:0]   dst_width;
		logic [DIM_W-1:0]   dst_height;
		logic [PITCH_W-1:0] dst_pitch;
		logic [DIM_W-1:0]   src_width;
		logic [DIM_W-1:0]   src_height;
		logic [PITCH_W-1:0] src_pitch;
	} cfg_t;

	typedef struct packed {
		cmd_t             cmd;
		logic [DIM_W-1:0] src_x;
		logic [DIM_W-1:0] src_y;
		logic [DIM_W-1:0] dst_x;
		logic [DIM_W-1:0] dst_y;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic             key_enable;
		logic [PIX_W-1:0] key_low;
		logic [PIX_W-1:0] key_high;
		logic [PIX_W-1:0] pixel;
	} item_t;

	typedef struct packed {
		cmd_t              kind;
		logic              accepted;
		logic              no_blit_error;
		logic              write_enable;
		logic [ADDR_W-1:0] dst_address;
		logic [PIX_W-1:0]  pixel_data;
		logic              last_pixel;
	} res_t;

endpackage

FILE: hw/rtl/ckrb_start_chk.sv
// start beat checks against the surfaces and first row base address
module ckrb_start_chk #(
	parameter int unsigned MAX_DIM   = ckrb_pkg::MAX_DIM,
	parameter int unsigned MAX_PITCH = ckrb_pkg::MAX_PITCH
) (
	input  ckrb_pkg::cfg_t                     cfg,
	input  ckrb_pkg::item_t                    item,
	output logic                               start_ok,
	output logic [ckrb_pkg::ADDR_W-1:0]        start_row_base
);

	localparam logic [ckrb_pkg::CMP_W-1:0] DIM_LIM   = ckrb_pkg::CMP_W'(MAX_DIM);
	localparam logic [ckrb_pkg::CMP_W-1:0] PITCH_LIM = ckrb_pkg::CMP_W'(MAX_PITCH);

	logic                                              oversize;
	logic                                              pitch_bad;
	logic                                              pos_bad;
	logic                                              fit_bad;
	logic [ckrb_pkg::DIM_W:0]                          dst_x_end;
	logic [ckrb_pkg::DIM_W:0]                          dst_y_end;
	logic [ckrb_pkg::DIM_W:0]                          src_x_end;
	logic [ckrb_pkg::DIM_W:0]                          src_y_end;
	logic [ckrb_pkg::DIM_W+ckrb_pkg::PITCH_W-1:0]      row_prod;

	assign oversize =
		(ckrb_pkg::CMP_W'(cfg.dst_width) > DIM_LIM) ||
		(ckrb_pkg::CMP_W'(cfg.dst_height) > DIM_LIM) ||
		(ckrb_pkg::CMP_W'(cfg.src_width) > DIM_LIM) ||
		(ckrb_pkg::CMP_W'(cfg.src_height) > DIM_LIM) ||
		(ckrb_pkg::CMP_W'(cfg.dst_pitch) >= PITCH_LIM) ||
		(ckrb_pkg::CMP_W'(cfg.src_pitch) >= PITCH_LIM);

	assign pitch_bad = (cfg.dst_pitch < {cfg.dst_width, 1'b0}) ||
		(cfg.src_pitch < {cfg.src_width, 1'b0});

	assign pos_bad = (item.dst_x > cfg.dst_width) || (item.dst_y > cfg.dst_height) ||
		(item.src_x > cfg.src_width) || (item.src_y > cfg.src_height);

	// position already known to lie inside, so end past the edge is the overflow test
	assign dst_x_end = {1'b0, item.dst_x} + {1'b0, item.rect_width};
	assign dst_y_end = {1'b0, item.dst_y} + {1'b0, item.rect_height};
	assign src_x_end = {1'b0, item.src_x} + {1'b0, item.rect_width};
	assign src_y_end = {1'b0, item.src_y} + {1'b0, item.rect_height};

	assign fit_bad = (dst_x_end > {1'b0, cfg.dst_width}) ||
		(dst_y_end > {1'b0, cfg.dst_height}) ||
		(src_x_end > {1'b0, cfg.src_width}) ||
		(src_y_end > {1'b0, cfg.src_height});

	assign start_ok = !oversize && (item.rect_width != '0) && (item.rect_height != '0) &&
		!pitch_bad && !pos_bad && !fit_bad;

	assign row_prod = (ckrb_pkg::DIM_W+ckrb_pkg::PITCH_W)'(item.dst_y) *
		(ckrb_pkg::DIM_W+ckrb_pkg::PITCH_W)'(cfg.dst_pitch);
	assign start_row_base = row_prod[ckrb_pkg::ADDR_W-1:0];

endmodule

FILE: hw/rtl/ckrb_walker.sv
// blit state: raster position, held rectangle and key, per-beat result
module ckrb_walker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               advance,
	input  ckrb_pkg::cfg_t                     cfg,
	input  ckrb_pkg::item_t                    item,
	input  logic                               start_ok,
	input  logic [ckrb_pkg::ADDR_W-1:0]        start_row_base,
	output ckrb_pkg::res_t                     res,
	output logic                               active
);

	logic                          active_q;
	logic [ckrb_pkg::DIM_W-1:0]    col_q;
	logic [ckrb_pkg::DIM_W-1:0]    row_q;
	logic [ckrb_pkg::ADDR_W-1:0]   row_base_q;
	logic [ckrb_pkg::DIM_W-1:0]    dst_x_q;
	logic [ckrb_pkg::DIM_W-1:0]    width_q;
	logic [ckrb_pkg::DIM_W-1:0]    height_q;
	logic                          key_on_q;
	logic [ckrb_pkg::PIX_W-1:0]    key_low_q;
	logic [ckrb_pkg::PIX_W-1:0]    key_high_q;

	logic [ckrb_pkg::DIM_W:0]      col_inc;
	logic [ckrb_pkg::DIM_W:0]      row_inc;
	logic [ckrb_pkg::DIM_W:0]      col_addr;
	logic [ckrb_pkg::ADDR_W-1:0]   pix_addr;
	logic                          last;
	logic                          keyed;
	logic                          wrap;

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign row_inc  = {1'b0, row_q} + 1'b1;
	assign last     = (col_inc >= {1'b0, width_q}) && (row_inc >= {1'b0, height_q});
	assign wrap     = col_inc[ckrb_pkg::DIM_W-1:0] >= width_q;
	assign col_addr = {1'b0, dst_x_q} + {1'b0, col_q};
	assign pix_addr = row_base_q + ckrb_pkg::ADDR_W'({col_addr, 1'b0});
	assign keyed    = key_on_q && (key_low_q <= key_high_q) &&
		(item.pixel >= key_low_q) && (item.pixel <= key_high_q);
	assign active   = active_q;

	always_comb begin
		res = '0;
		unique case (item.cmd)
			ckrb_pkg::CMD_START: begin
				res.kind     = ckrb_pkg::CMD_START;
				res.accepted = start_ok;
			end
			ckrb_pkg::CMD_PIXEL: begin
				res.kind = ckrb_pkg::CMD_PIXEL;
				if (!active_q) begin
					res.no_blit_error = 1'b1;
				end else begin
					res.write_enable = !keyed;
					res.dst_address  = pix_addr;
					res.pixel_data   = item.pixel;
					res.last_pixel   = last;
				end
			end
			default: res = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			row_base_q <= '0;
			dst_x_q    <= '0;
			width_q    <= '0;
			height_q   <= '0;
			key_on_q   <= 1'b0;
			key_low_q  <= '0;
			key_high_q <= '0;
		end else if (advance) begin
			if (item.cmd == ckrb_pkg::CMD_START) begin
				active_q <= start_ok;
				if (start_ok) begin
					col_q      <= '0;
					row_q      <= '0;
					row_base_q <= start_row_base;
					dst_x_q    <= item.dst_x;
					width_q    <= item.rect_width;
					height_q   <= item.rect_height;
					key_on_q   <= item.key_enable;
					key_low_q  <= item.key_low;
					key_high_q <= item.key_high;
				end
			end else if (active_q) begin
				if (wrap) begin
					col_q      <= '0;
					row_q      <= row_inc[ckrb_pkg::DIM_W-1:0];
					row_base_q <= row_base_q + ckrb_pkg::ADDR_W'(cfg.dst_pitch);
				end else begin
					col_q <= col_inc[ckrb_pkg::DIM_W-1:0];
				end
				if (last) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/color_keyed_rect_blit_unit.sv
// top level: configuration registers, input stage, result register
// a taken beat is registered in the input stage, then its result in the result register
// throughput: one beat per cycle while result_stall is low, set by the walker stage
// a waiting result holds the input stage; a new beat enters only when that stage is empty or moving on
// reset: asynchronous, clears configuration, blit state and both stage valids
module color_keyed_rect_blit_unit #(
	parameter int unsigned MAX_DIM   = ckrb_pkg::MAX_DIM,
	parameter int unsigned MAX_PITCH = ckrb_pkg::MAX_PITCH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ckrb_pkg::IDX_W-1:0]        cfg_index,
	input  logic [ckrb_pkg::PITCH_W-1:0]      cfg_data,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              cmd,
	input  logic [ckrb_pkg::DIM_W-1:0]        src_x,
	input  logic [ckrb_pkg::DIM_W-1:0]        src_y,
	input  logic [ckrb_pkg::DIM_W-1:0]        dst_x,
	input  logic [ckrb_pkg::DIM_W-1:0]        dst_y,
	input  logic [ckrb_pkg::DIM_W-1:0]        rect_width,
	input  logic [ckrb_pkg::DIM_W-1:0]        rect_height,
	input  logic                              key_enable,
	input  logic [ckrb_pkg::PIX_W-1:0]        key_low,
	input  logic [ckrb_pkg::PIX_W-1:0]        key_high,
	input  logic [ckrb_pkg::PIX_W-1:0]        pixel,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic                              kind,
	output logic                              accepted,
	output logic                              no_blit_error,
	output logic                              write_enable,
	output logic [ckrb_pkg::ADDR_W-1:0]       dst_address,
	output logic [ckrb_pkg::PIX_W-1:0]        pixel_data,
	output logic                              last_pixel
);

	ckrb_pkg::cfg_t                  cfg_q;
	ckrb_pkg::item_t                 item_s1;
	logic                            valid_s1;
	ckrb_pkg::res_t                  res_s2;
	logic                            valid_s2;
	ckrb_pkg::res_t                  res_next;
	logic                            advance;
	logic                            take;
	logic                            start_ok;
	logic [ckrb_pkg::ADDR_W-1:0]     start_row_base;
	logic                            active;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				ckrb_pkg::REG_DST_WIDTH:  cfg_q.dst_width  <= cfg_data[ckrb_pkg::DIM_W-1:0];
				ckrb_pkg::REG_DST_HEIGHT: cfg_q.dst_height <= cfg_data[ckrb_pkg::DIM_W-1:0];
				ckrb_pkg::REG_DST_PITCH:  cfg_q.dst_pitch  <= cfg_data;
				ckrb_pkg::REG_SRC_WIDTH:  cfg_q.src_width  <= cfg_data[ckrb_pkg::DIM_W-1:0];
				ckrb_pkg::REG_SRC_HEIGHT: cfg_q.src_height <= cfg_data[ckrb_pkg::DIM_W-1:0];
				ckrb_pkg::REG_SRC_PITCH:  cfg_q.src_pitch  <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	// input stage moves on whenever the result register is empty or being drained
	assign advance    = valid_s1 && (!valid_s2 || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign take       = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{
				cmd:         ckrb_pkg::cmd_t'(cmd),
				src_x:       src_x,
				src_y:       src_y,
				dst_x:       dst_x,
				dst_y:       dst_y,
				rect_width:  rect_width,
				rect_height: rect_height,
				key_enable:  key_enable,
				key_low:     key_low,
				key_high:    key_high,
				pixel:       pixel
			};
		end
	end

	ckrb_start_chk #(
		.MAX_DIM   (MAX_DIM),
		.MAX_PITCH (MAX_PITCH)
	) u_chk (
		.cfg            (cfg_q),
		.item           (item_s1),
		.start_ok       (start_ok),
		.start_row_base (start_row_base)
	);

	ckrb_walker u_walk (
		.clk            (clk),
		.arst_n         (arst_n),
		.advance        (advance),
		.cfg            (cfg_q),
		.item           (item_s1),
		.start_ok       (start_ok),
		.start_row_base (start_row_base),
		.res            (res_next),
		.active         (active)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid  = valid_s2;
	assign kind          = res_s2.kind;
	assign accepted      = res_s2.accepted;
	assign no_blit_error = res_s2.no_blit_error;
	assign write_enable  = res_s2.write_enable;
	assign dst_address   = res_s2.dst_address;
	assign pixel_data    = res_s2.pixel_data;
	assign last_pixel    = res_s2.last_pixel;

	a_last_ends_blit: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.cmd == ckrb_pkg::CMD_PIXEL) && active && res_next.last_pixel
		|=> !active)
		else $error("blit still running after its final pixel");

	a_start_sets_active: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.cmd == ckrb_pkg::CMD_START)
		|=> (active == $past(start_ok)) && result_valid && (kind == ckrb_pkg::CMD_START))
		else $error("start beat did not set blit state and answer");

	a_error_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && no_blit_error |-> !write_enable && !accepted && (dst_address == '0))
		else $error("pixel without blit carries a write");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && valid_s2 && result_stall)
		else $error("input stalled with room downstream");

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the colour-keyed rectangle blitter: directed and random beats
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ckrb_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int BEATS_PER_PHASE = 200;
	localparam int N_PHASES = 8;
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [PITCH_W-1:0] cfg_data = '0;

	logic item_valid = 1'b0;
	logic item_stall;
	item_t beat_out = '0;

	logic result_valid;
	logic result_stall = 1'b0;
	logic kind, accepted, no_blit_error, write_enable, last_pixel;
	logic [ADDR_W-1:0] dst_address;
	logic [PIX_W-1:0] pixel_data;

	// beats waiting to be sent, and blit results still owed by the block
	item_t beat_queue[$];
	res_t blit_expect[$];

	// surface registers as the block should hold them
	cfg_t cfg_shadow = '0;

	// blit walker state
	logic blit_on = 1'b0;
	logic [DIM_W-1:0] blit_col = '0, blit_row = '0, blit_dx = '0, blit_w = '0, blit_h = '0;
	logic [ADDR_W-1:0] blit_row_base = '0;
	logic key_on = 1'b0;
	logic [PIX_W-1:0] key_lo = '0, key_hi = '0;

	logic item_taken = 1'b0;
	bit sender_bursty = 1'b1;
	bit receiver_stalls = 1'b1;
	int gap_left = 0;
	int burst_left = 0;
	logic [12:0] stall_pat = '0;
	int stall_age = 0;

	int queued_beats = 0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_beats = 0, n_starts = 0, n_accepted = 0;
	int n_written = 0, n_keyed = 0, n_flagged = 0, n_settings = 0;

	color_keyed_rect_blit_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.item_valid    (item_valid),
		.item_stall    (item_stall),
		.cmd           (beat_out.cmd),
		.src_x         (beat_out.src_x),
		.src_y         (beat_out.src_y),
		.dst_x         (beat_out.dst_x),
		.dst_y         (beat_out.dst_y),
		.rect_width    (beat_out.rect_width),
		.rect_height   (beat_out.rect_height),
		.key_enable    (beat_out.key_enable),
		.key_low       (beat_out.key_low),
		.key_high      (beat_out.key_high),
		.pixel         (beat_out.pixel),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.kind          (kind),
		.accepted      (accepted),
		.no_blit_error (no_blit_error),
		.write_enable  (write_enable),
		.dst_address   (dst_address),
		.pixel_data    (pixel_data),
		.last_pixel    (last_pixel)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic res_t blit_predict(item_t b);
		res_t r;
		int unsigned dw, dh, dp, sw, sh, sp;
		logic fits, at_end;
		r = '0;
		r.kind = b.cmd;
		dw = cfg_shadow.dst_width;
		dh = cfg_shadow.dst_height;
		dp = cfg_shadow.dst_pitch;
		sw = cfg_shadow.src_width;
		sh = cfg_shadow.src_height;
		sp = cfg_shadow.src_pitch;
		if (b.cmd == CMD_START) begin
			fits = dw <= MAX_DIM && dh <= MAX_DIM && sw <= MAX_DIM && sh <= MAX_DIM
				&& dp < MAX_PITCH && sp < MAX_PITCH
				&& b.rect_width != 0 && b.rect_height != 0
				&& dp >= 2 * dw && sp >= 2 * sw
				&& b.dst_x <= dw && b.dst_y <= dh && b.src_x <= sw && b.src_y <= sh;
			if (fits) begin
				fits = b.rect_width <= dw - b.dst_x && b.rect_height <= dh - b.dst_y
					&& b.rect_width <= sw - b.src_x && b.rect_height <= sh - b.src_y;
			end
			r.accepted = fits;
			blit_on = fits;
			if (fits) begin
				blit_col = '0;
				blit_row = '0;
				blit_row_base = ADDR_W'(b.dst_y * dp);
				blit_dx = b.dst_x;
				blit_w = b.rect_width;
				blit_h = b.rect_height;
				key_on = b.key_enable;
				key_lo = b.key_low;
				key_hi = b.key_high;
			end
		end else if (!blit_on) begin
			r.no_blit_error = 1'b1;
		end else begin
			at_end = (blit_col + 1 >= blit_w) && (blit_row + 1 >= blit_h);
			r.write_enable = !(key_on && key_lo <= key_hi
				&& b.pixel >= key_lo && b.pixel <= key_hi);
			r.dst_address = ADDR_W'(blit_row_base + (blit_dx + blit_col) * 2);
			r.pixel_data = b.pixel;
			r.last_pixel = at_end;
			blit_col = blit_col + 1'b1;
			// row step uses the pitch register as it stands now
			if (blit_col >= blit_w) begin
				blit_col = '0;
				blit_row = blit_row + 1'b1;
				blit_row_base = ADDR_W'(blit_row_base + dp);
			end
			if (at_end) blit_on = 1'b0;
		end
		return r;
	endfunction

	function automatic string show_result(res_t r);
		return $sformatf("kind=%0d acc=%0b err=%0b we=%0b addr=%h data=%h last=%0b",
			r.kind, r.accepted, r.no_blit_error, r.write_enable, r.dst_address,
			r.pixel_data, r.last_pixel);
	endfunction

	// sender: bursts of beats, with random gaps only while sender_bursty is set
	always @(negedge clk) begin : beat_driver
		logic send;
		send = 1'b0;
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
			end else if (beat_queue.size() != 0) begin
				send = 1'b1;
				beat_out <= beat_queue.pop_front();
				if (burst_left > 1) begin
					burst_left = burst_left - 1;
				end else begin
					burst_left = $urandom_range(1, 16);
					gap_left = sender_bursty ? $urandom_range(0, 8) : 0;
				end
			end
			item_valid <= send;
		end
	end

	// receiver: rotating stall pattern, reseeded now and then, never all ones, used only when receiver_stalls is set
	always @(negedge clk) begin : stall_driver
		if (stall_age == 0) begin
			stall_pat = $urandom_range(0, 1) ? 13'($urandom & $urandom) : 13'($urandom | $urandom);
			stall_pat[0] = 1'b0;
		end
		stall_age = (stall_age + 1) % 200;
		result_stall <= receiver_stalls && stall_pat[0];
		stall_pat = {stall_pat[0], stall_pat[12:1]};
	end

	always @(posedge clk) begin : beat_monitor
		res_t want, got;
		if (arst_n) begin
			item_taken <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				got.kind = cmd_t'(kind);
				got.accepted = accepted;
				got.no_blit_error = no_blit_error;
				got.write_enable = write_enable;
				got.dst_address = dst_address;
				got.pixel_data = pixel_data;
				got.last_pixel = last_pixel;
				if (blit_expect.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result: %s", show_result(got));
				end else begin
					want = blit_expect.pop_front();
					if (got.kind !== want.kind || got.accepted !== want.accepted
						|| got.no_blit_error !== want.no_blit_error
						|| got.write_enable !== want.write_enable
						|| got.dst_address !== want.dst_address
						|| got.pixel_data !== want.pixel_data
						|| got.last_pixel !== want.last_pixel) begin
						errors++;
						if (errors <= 10) begin
							$display("mismatch at %0t: expected %s", $realtime, show_result(want));
							$display("                 actual   %s", show_result(got));
						end
					end
				end
			end
			if (item_valid && !item_stall) begin
				want = blit_predict(beat_out);
				blit_expect.push_back(want);
				n_beats++;
				if (want.kind == CMD_START) begin
					n_starts++;
					if (want.accepted) n_accepted++;
				end else if (want.no_blit_error) begin
					n_flagged++;
				end else if (want.write_enable) begin
					n_written++;
				end else begin
					n_keyed++;
				end
			end
			if ((item_valid && !item_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
	end

	initial begin : watchdog
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Regression FAIL");
		$finish;
	end

	task automatic cfg_write(input logic [IDX_W-1:0] idx, input logic [PITCH_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DST_WIDTH:  cfg_shadow.dst_width = data[DIM_W-1:0];
			REG_DST_HEIGHT: cfg_shadow.dst_height = data[DIM_W-1:0];
			REG_DST_PITCH:  cfg_shadow.dst_pitch = data;
			REG_SRC_WIDTH:  cfg_shadow.src_width = data[DIM_W-1:0];
			REG_SRC_HEIGHT: cfg_shadow.src_height = data[DIM_W-1:0];
			REG_SRC_PITCH:  cfg_shadow.src_pitch = data;
			default: ;
		endcase
	endtask

	// surface setting per phase; dimension writes carry a random bit above the register
	task automatic configure_phase(input int p);
		int unsigned dw, dh, dp, sw, sh, sp;
		case (p)
			0: begin dw = 64; dh = 48; dp = 128; sw = 80; sh = 60; sp = 200; end
			1: begin dw = 4096; dh = 4096; dp = 16383; sw = 4096; sh = 4096; sp = 8192; end
			2: begin dw = 1; dh = 1; dp = 2; sw = 1; sh = 1; sp = 16383; end
			3: begin dw = 20; dh = 10; dp = 39; sw = 20; sh = 10; sp = 40; end
			4: begin dw = 4097; dh = 30; dp = 16383; sw = 40; sh = 40; sp = 80; end
			5: begin dw = 30; dh = 20; dp = 60; sw = 50; sh = 20; sp = 99; end
			default: begin
				dw = $urandom_range(0, 3) != 0 ? $urandom_range(1, 100) : $urandom_range(0, 4096);
				dh = $urandom_range(0, 3) != 0 ? $urandom_range(1, 100) : $urandom_range(0, 4096);
				sw = $urandom_range(0, 3) != 0 ? $urandom_range(1, 100) : $urandom_range(0, 4096);
				sh = $urandom_range(0, 3) != 0 ? $urandom_range(1, 100) : $urandom_range(0, 4096);
				dp = 2 * dw + $urandom_range(0, 50);
				sp = 2 * sw + $urandom_range(0, 50);
				if (dp > 16383) dp = 16383;
				if (sp > 16383) sp = 16383;
			end
		endcase
		cfg_write(REG_DST_WIDTH, PITCH_W'(dw) | PITCH_W'($urandom_range(0, 1) << DIM_W));
		cfg_write(REG_DST_HEIGHT, PITCH_W'(dh) | PITCH_W'($urandom_range(0, 1) << DIM_W));
		cfg_write(REG_DST_PITCH, PITCH_W'(dp));
		cfg_write(REG_SRC_WIDTH, PITCH_W'(sw) | PITCH_W'($urandom_range(0, 1) << DIM_W));
		cfg_write(REG_SRC_HEIGHT, PITCH_W'(sh) | PITCH_W'($urandom_range(0, 1) << DIM_W));
		cfg_write(REG_SRC_PITCH, PITCH_W'(sp));
		if (p == 0) begin
			cfg_write(IDX_SPARE_LO, PITCH_W'($urandom));
			cfg_write(IDX_SPARE_HI, PITCH_W'($urandom));
		end
		@(negedge clk);
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	task automatic push_start(input int unsigned sx, sy, dx, dy, w, h,
		input bit ken, input int unsigned klo, khi);
		item_t b;
		b = {$urandom, $urandom, $urandom, $urandom};
		b.cmd = CMD_START;
		b.src_x = DIM_W'(sx);
		b.src_y = DIM_W'(sy);
		b.dst_x = DIM_W'(dx);
		b.dst_y = DIM_W'(dy);
		b.rect_width = DIM_W'(w);
		b.rect_height = DIM_W'(h);
		b.key_enable = ken;
		b.key_low = PIX_W'(klo);
		b.key_high = PIX_W'(khi);
		beat_queue.push_back(b);
		queued_beats++;
	endtask

	task automatic push_pixel(input int unsigned px);
		item_t b;
		b = {$urandom, $urandom, $urandom, $urandom};
		b.cmd = CMD_PIXEL;
		b.pixel = PIX_W'(px);
		beat_queue.push_back(b);
		queued_beats++;
	endtask

	// a start that mostly fits the current surfaces, then its pixels in raster order
	task automatic queue_blit(input bit cut_short);
		int unsigned dw, dh, sw, sh, w, h, dx, dy, sx, sy, n, lo, hi, t;
		bit ken;
		dw = cfg_shadow.dst_width;
		dh = cfg_shadow.dst_height;
		sw = cfg_shadow.src_width;
		sh = cfg_shadow.src_height;
		w = $urandom_range(0, 9) == 0 ? $urandom_range(1, 40) : $urandom_range(1, 6);
		h = w > 8 ? $urandom_range(1, 2) : $urandom_range(1, 6);
		if (w > dw) w = dw;
		if (w > sw) w = sw;
		if (h > dh) h = dh;
		if (h > sh) h = sh;
		if (w == 0) w = 1;
		if (h == 0) h = 1;
		dx = dw >= w ? ($urandom_range(0, 7) == 0 ? dw - w : $urandom_range(0, dw - w)) : 0;
		dy = dh >= h ? ($urandom_range(0, 7) == 0 ? dh - h : $urandom_range(0, dh - h)) : 0;
		sx = sw >= w ? ($urandom_range(0, 7) == 0 ? sw - w : $urandom_range(0, sw - w)) : 0;
		sy = sh >= h ? ($urandom_range(0, 7) == 0 ? sh - h : $urandom_range(0, sh - h)) : 0;
		// just over the edge now and then
		case ($urandom_range(0, 39))
			0: dx++;
			1: dy++;
			2: sx++;
			3: sy++;
			default: ;
		endcase
		ken = $urandom_range(0, 3) != 0;
		lo = $urandom_range(0, 65535);
		hi = lo + $urandom_range(0, 4000);
		if (hi > 65535) hi = 65535;
		case ($urandom_range(0, 9))
			0: begin lo = 0; hi = 65535; end
			1: begin t = lo; lo = hi; hi = t; end
			2: hi = lo;
			default: ;
		endcase
		push_start(sx, sy, dx, dy, w, h, ken, lo, hi);
		n = w * h;
		if (cut_short) n = $urandom_range(0, n - 1);
		else if ($urandom_range(0, 6) == 0) n = n + $urandom_range(1, 2);
		else if ($urandom_range(0, 6) == 0) n = $urandom_range(0, n - 1);
		repeat (n) begin
			if (lo <= hi && $urandom_range(0, 1)) push_pixel($urandom_range(lo, hi));
			else push_pixel($urandom_range(0, 65535));
		end
	endtask

	task automatic wait_drained();
		while (beat_queue.size() != 0 || item_valid || blit_expect.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	initial begin : stimulus
		int mark;
		item_t b;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset surfaces are empty: nothing can start
		push_pixel(16'hFFFF);
		push_start(0, 0, 0, 0, 1, 1, 1'b0, 0, 0);
		wait_drained();

		configure_phase(1);
		push_start(0, 0, 8191, 8191, 1, 1, 1'b0, 0, 0);
		push_start(0, 0, 0, 0, 0, 1, 1'b0, 0, 0);
		push_start(0, 0, 0, 0, 1, 0, 1'b0, 0, 0);
		push_start(8191, 8191, 0, 0, 8191, 8191, 1'b1, 0, 16'hFFFF);
		push_start(4095, 0, 0, 0, 2, 1, 1'b0, 0, 0);
		push_start(4096, 4096, 4096, 4096, 1, 1, 1'b0, 0, 0);
		// 2x2 in the far corner, key range edges
		push_start(4094, 4094, 4094, 4094, 2, 2, 1'b1, 16'h0010, 16'h0020);
		push_pixel(16'h000F);
		push_pixel(16'h0010);
		push_pixel(16'h0020);
		push_pixel(16'h0021);
		push_pixel(16'h1234);
		// inverted key range keys nothing
		push_start(0, 0, 0, 0, 3, 1, 1'b1, 16'h8000, 16'h7FFF);
		push_pixel(16'h7FFF);
		// replaced mid-blit
		push_start(4095, 4095, 4095, 4095, 1, 1, 1'b1, 16'hFFFF, 16'hFFFF);
		push_pixel(16'hFFFF);
		push_start(0, 0, 0, 0, 4, 1, 1'b1, 0, 16'hFFFF);
		push_pixel(16'h0000);
		// rejected start ends the running blit
		push_start(0, 0, 0, 0, 0, 0, 1'b1, 0, 16'hFFFF);
		push_pixel(16'h0000);
		push_start(0, 0, 0, 4094, 1, 2, 1'b0, 0, 16'hFFFF);
		push_pixel(16'h0000);
		push_pixel(16'h5555);
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			sender_bursty = (p % 4) < 2;
			receiver_stalls = (p % 4) == 0 || (p % 4) == 2;
			configure_phase(p);
			// continue whatever blit the last phase left open, on the new pitch
			repeat (3) push_pixel($urandom_range(0, 65535));
			mark = queued_beats;
			while (queued_beats - mark < BEATS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					b = {$urandom, $urandom, $urandom, $urandom};
					beat_queue.push_back(b);
					queued_beats++;
				end else begin
					queue_blit(1'b0);
				end
			end
			queue_blit(1'b1);
			wait_drained();
		end

		while (blit_expect.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("covered %0d beats over %0d surface settings: %0d starts, %0d accepted",
			n_beats, n_settings, n_starts, n_accepted);
		$display("pixels: %0d written, %0d keyed out, %0d flagged with no blit; %0d mismatches",
			n_written, n_keyed, n_flagged, errors);
		if (errors == 0 && blit_expect.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
